// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL, clocked on aclk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/utf8sd_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int MAX_TAB_SPACES_DEF = 16;
    localparam int TAB_W              = 5;
    localparam int CP_W               = 21;
    localparam int CNT_W              = 16;
    localparam int S_TDATA_W          = 8;
    localparam int M_TDATA_W          = 40;
    localparam int M_TUSER_W          = 2;

    localparam logic [TAB_W-1:0] TAB_WIDTH_RST = 5'd4;

    localparam logic [7:0]      BYTE_CR   = 8'h0D;
    localparam logic [7:0]      BYTE_TAB  = 8'h09;
    localparam logic [CP_W-1:0] CP_QMARK  = 21'd63;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'h20;
    localparam logic [CP_W-1:0] CP_MIN2   = 21'h80;
    localparam logic [CP_W-1:0] CP_MIN3   = 21'h800;
    localparam logic [CP_W-1:0] CP_MIN4   = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'hD800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'hDFFF;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  pv;
        logic [1:0]       rem;
        logic [2:0]       slen;
        logic             skip;
        logic [CNT_W-1:0] tally;
    } dec_state_t;

    // Results of one byte: optional '?', main run, optional trailing '?'.
    typedef struct packed {
        logic             pre_q;
        logic [CNT_W-1:0] pre_cnt;
        logic [CP_W-1:0]  main_cp;
        logic             main_has;
        logic [CNT_W-1:0] main_cnt;
        logic             post_q;
        logic [CNT_W-1:0] post_cnt;
        logic             eot;
    } plan_t;

endpackage

// ===== hw/rtl/utf8sd_decode.sv =====
// Per-byte UTF-8 decode: next decoder state and the result plan of one byte.
module utf8sd_decode #(
    parameter int MAX_TAB_SPACES = utf8sd_pkg::MAX_TAB_SPACES_DEF
) (
    input  utf8sd_pkg::dec_state_t              st_i,
    input  logic [7:0]                          byte_i,
    input  logic                                eot_i,
    input  logic [utf8sd_pkg::TAB_W-1:0]        tab_width_i,
    output utf8sd_pkg::dec_state_t              st_o,
    output utf8sd_pkg::plan_t                   plan_o,
    output logic [$clog2(MAX_TAB_SPACES+1)-1:0] rep_o
);

    localparam int REP_W = $clog2(MAX_TAB_SPACES + 1);

    function automatic logic [utf8sd_pkg::CNT_W-1:0] sat_inc(
        input logic [utf8sd_pkg::CNT_W-1:0] v
    );
        return (v == '1) ? v : v + 1'b1;
    endfunction

    logic [utf8sd_pkg::CP_W-1:0]  pv2;
    logic [utf8sd_pkg::CP_W-1:0]  min_cp;
    logic                         seq_ok;
    logic                         is_cont;
    logic                         lead;
    logic                         main_inv;
    logic [REP_W-1:0]             tab_rep;
    logic [utf8sd_pkg::CNT_W-1:0] t_pre;
    logic [utf8sd_pkg::CNT_W-1:0] t_main;
    logic [utf8sd_pkg::CNT_W-1:0] t_post;

    always_comb begin
        is_cont = (byte_i[7:6] == 2'b10);
        pv2     = {st_i.pv[14:0], byte_i[5:0]};
        unique case (st_i.slen)
            utf8sd_pkg::SEQ_LEN2: min_cp = utf8sd_pkg::CP_MIN2;
            utf8sd_pkg::SEQ_LEN3: min_cp = utf8sd_pkg::CP_MIN3;
            default:              min_cp = utf8sd_pkg::CP_MIN4;
        endcase
        seq_ok = (pv2 >= min_cp) && (pv2 <= utf8sd_pkg::CP_MAX) &&
                 !((pv2 >= utf8sd_pkg::SURR_LO) && (pv2 <= utf8sd_pkg::SURR_HI));

        if (tab_width_i == '0) begin
            tab_rep = REP_W'(1);
        end else if (32'(tab_width_i) > MAX_TAB_SPACES) begin
            tab_rep = REP_W'(MAX_TAB_SPACES);
        end else begin
            tab_rep = REP_W'(tab_width_i);
        end

        st_o            = st_i;
        plan_o          = '0;
        plan_o.main_has = 1'b1;
        plan_o.eot      = eot_i;
        rep_o           = '0;
        lead            = 1'b0;
        main_inv        = 1'b0;

        if (st_i.rem != 2'd0) begin
            if (is_cont) begin
                st_o.pv  = pv2;
                st_o.rem = st_i.rem - 2'd1;
                if (st_i.rem == 2'd1) begin
                    st_o.pv   = '0;
                    st_o.slen = '0;
                    rep_o     = REP_W'(1);
                    if (seq_ok) begin
                        plan_o.main_cp = pv2;
                    end else begin
                        plan_o.main_cp = utf8sd_pkg::CP_QMARK;
                        main_inv       = 1'b1;
                        st_o.skip      = 1'b1;
                    end
                end
            end else begin
                plan_o.pre_q = 1'b1;
                st_o.pv      = '0;
                st_o.rem     = '0;
                st_o.slen    = '0;
                st_o.skip    = 1'b0;
                lead         = 1'b1;
            end
        end else if (st_i.skip && is_cont) begin
            st_o.skip = 1'b1;
        end else begin
            st_o.skip = 1'b0;
            lead      = 1'b1;
        end

        if (lead) begin
            priority if (byte_i == utf8sd_pkg::BYTE_CR) begin
                rep_o = '0;
            end else if (byte_i == utf8sd_pkg::BYTE_TAB) begin
                rep_o          = tab_rep;
                plan_o.main_cp = utf8sd_pkg::CP_SPACE;
            end else if (!byte_i[7]) begin
                rep_o          = REP_W'(1);
                plan_o.main_cp = {13'd0, byte_i};
            end else if (byte_i[7:5] == 3'b110) begin
                st_o.pv   = {16'd0, byte_i[4:0]};
                st_o.slen = utf8sd_pkg::SEQ_LEN2;
                st_o.rem  = 2'd1;
            end else if (byte_i[7:4] == 4'b1110) begin
                st_o.pv   = {17'd0, byte_i[3:0]};
                st_o.slen = utf8sd_pkg::SEQ_LEN3;
                st_o.rem  = 2'd2;
            end else if (byte_i[7:3] == 5'b11110) begin
                st_o.pv   = {18'd0, byte_i[2:0]};
                st_o.slen = utf8sd_pkg::SEQ_LEN4;
                st_o.rem  = 2'd3;
            end else begin
                rep_o          = REP_W'(1);
                plan_o.main_cp = utf8sd_pkg::CP_QMARK;
                main_inv       = 1'b1;
                st_o.skip      = 1'b1;
            end
        end

        // truncated sequence at end of text
        if (eot_i && (st_o.rem != 2'd0)) begin
            plan_o.post_q = 1'b1;
        end
        // silent final byte gets an empty marker
        if (eot_i && !plan_o.pre_q && (rep_o == '0) && !plan_o.post_q) begin
            rep_o           = REP_W'(1);
            plan_o.main_cp  = '0;
            plan_o.main_has = 1'b0;
        end

        t_pre  = plan_o.pre_q  ? sat_inc(st_i.tally) : st_i.tally;
        t_main = main_inv      ? sat_inc(t_pre)      : t_pre;
        t_post = plan_o.post_q ? sat_inc(t_main)     : t_main;
        plan_o.pre_cnt  = t_pre;
        plan_o.main_cnt = t_main;
        plan_o.post_cnt = t_post;
        st_o.tally      = t_post;

        if (eot_i) begin
            st_o = '0;
        end
    end

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: input skid, decode, result sequencer.
//
//  channel | dir | transfer                 | payload
//  --------+-----+--------------------------+--------------------------------------
//  s_      | in  | s_tvalid & s_tready      | tdata = in_byte, tlast = end_of_text
//  m_      | out | m_tvalid & m_tready      | tdata = code_point, invalid_count;
//          |     |                          | tlast = last_of_run; tuser = flags
//  cfg_    | in  | cfg_wr_en                | tab_width
//
//  One byte per cycle while each byte yields at most one result and m_tready stays high;
//  a tab holds the result register for its run of spaces (1..MAX_TAB_SPACES of them), and
//  a '?' for an interrupted sequence or for one cut off at end of text adds one result each.
//  The result register is the limit.
//  s_tready is registered from a one-entry skid buffer.
//  Reset is synchronous: decoder state clears and tab_width returns to 4.
module utf8_stream_decoder_top #(
    parameter int MAX_TAB_SPACES = utf8sd_pkg::MAX_TAB_SPACES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [utf8sd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,   // end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utf8sd_pkg::M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [36:21] invalid_count
    output logic [utf8sd_pkg::M_TUSER_W-1:0] m_tuser,   // [0] has_code_point, [1] text_done
    output logic                             m_tlast,   // last_of_run
    input  logic                             cfg_wr_en,
    input  logic [utf8sd_pkg::TAB_W-1:0]     cfg_wr_data // tab_width
);

`include "assert_macros.svh"

    localparam int REP_W = $clog2(MAX_TAB_SPACES + 1);

    logic [utf8sd_pkg::TAB_W-1:0] tab_width_reg;
    logic                         skid_valid_reg;
    logic [7:0]                   skid_byte_reg;
    logic                         skid_eot_reg;
    utf8sd_pkg::dec_state_t       state_reg;
    utf8sd_pkg::dec_state_t       state_next;
    utf8sd_pkg::plan_t            plan_reg;
    utf8sd_pkg::plan_t            plan_next;
    logic [REP_W-1:0]             rep_reg;
    logic [REP_W-1:0]             rep_next;

    logic       s_xfer;
    logic       m_xfer;
    logic       front_pre;
    logic       front_main;
    logic       last;
    logic       can_load;
    logic       load;
    logic [7:0] ld_byte;
    logic       ld_eot;

    assign s_tready = !skid_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    assign front_pre  = plan_reg.pre_q;
    assign front_main = !plan_reg.pre_q && (rep_reg != '0);

    always_comb begin
        if (front_pre) begin
            last = (rep_reg == '0) && !plan_reg.post_q;
        end else if (front_main) begin
            last = (rep_reg == REP_W'(1)) && !plan_reg.post_q;
        end else begin
            last = 1'b1;
        end
    end

    assign m_tvalid = plan_reg.pre_q || (rep_reg != '0) || plan_reg.post_q;
    assign m_tlast  = last;
    assign m_tuser  = {last && plan_reg.eot, front_main ? plan_reg.main_has : 1'b1};
    assign m_tdata  = {3'd0,
                       front_pre  ? plan_reg.pre_cnt  :
                       front_main ? plan_reg.main_cnt : plan_reg.post_cnt,
                       front_main ? plan_reg.main_cp  : utf8sd_pkg::CP_QMARK};

    assign can_load = !m_tvalid || (m_xfer && last);
    assign load     = can_load && (skid_valid_reg || s_xfer);
    assign ld_byte  = skid_valid_reg ? skid_byte_reg : s_tdata;
    assign ld_eot   = skid_valid_reg ? skid_eot_reg  : s_tlast;

    utf8sd_decode #(
        .MAX_TAB_SPACES (MAX_TAB_SPACES)
    ) u_decode (
        .st_i        (state_reg),
        .byte_i      (ld_byte),
        .eot_i       (ld_eot),
        .tab_width_i (tab_width_reg),
        .st_o        (state_next),
        .plan_o      (plan_next),
        .rep_o       (rep_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg  <= utf8sd_pkg::TAB_WIDTH_RST;
            skid_valid_reg <= 1'b0;
            state_reg      <= '0;
            plan_reg.pre_q <= 1'b0;
            plan_reg.post_q <= 1'b0;
            rep_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                tab_width_reg <= cfg_wr_data;
            end
            if (s_xfer && !can_load) begin
                skid_valid_reg <= 1'b1;
                skid_byte_reg  <= s_tdata;
                skid_eot_reg   <= s_tlast;
            end else if (load) begin
                skid_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg <= state_next;
                plan_reg  <= plan_next;
                rep_reg   <= rep_next;
            end else if (m_xfer) begin
                if (plan_reg.pre_q) begin
                    plan_reg.pre_q <= 1'b0;
                end else if (rep_reg != '0) begin
                    rep_reg <= rep_reg - REP_W'(1);
                end else begin
                    plan_reg.post_q <= 1'b0;
                end
            end
        end
    end

    `ASSERT_CLK(a_done_is_last, m_tvalid && m_tuser[1] |-> m_tlast)
    `ASSERT_CLK(a_marker_at_end,
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata[20:0] == '0))
    `ASSERT_CLK(a_tally_clears, load && ld_eot |=> state_reg.tally == '0)
    `ASSERT_NEVER(a_skid_without_result, skid_valid_reg && !m_tvalid)

endmodule

// ===== dv/utf8_stream_decoder_top_tb.sv =====
// Self-checking testbench for utf8_stream_decoder_top: directed table, then random UTF-8 text.
module utf8_stream_decoder_top_tb;

    localparam int TAB_MAX      = utf8sd_pkg::MAX_TAB_SPACES_DEF;
    localparam int CP_W         = utf8sd_pkg::CP_W;
    localparam int CNT_W        = utf8sd_pkg::CNT_W;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 46;
    localparam int DRAIN_CYCLES = 2 * TAB_MAX + 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 50;

    localparam int         SRC_IDLE   [PHASES] = '{0, 85, 0, 12, 0, 12};
    localparam int         SINK_STALL [PHASES] = '{0, 0, 85, 12, 0, 12};
    localparam logic [4:0] TAB_SET    [PHASES] = '{5'd4, 5'd0, 5'd31, 5'd16, 5'd1, 5'd9};

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic             has;
        logic             last;
        logic             done;
        logic [CNT_W-1:0] cnt;
    } cp_result_t;

    typedef struct packed {
        logic [7:0]       b;
        logic             eot;
        logic             typed;
        logic [CP_W-1:0]  cp;
        logic             has;
        logic [CNT_W-1:0] cnt;
    } stim_row_t;

    // typed rows carry a single known result; the rest go through the decoder model
    localparam stim_row_t DIR_ROWS [27] = '{
        '{8'h41,                1'b0, 1'b1, 21'h41,               1'b1, 16'd0},
        '{8'h00,                1'b0, 1'b1, 21'h00,               1'b1, 16'd0},
        '{8'h7F,                1'b0, 1'b1, 21'h7F,               1'b1, 16'd0},
        '{utf8sd_pkg::BYTE_CR,  1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{utf8sd_pkg::BYTE_TAB, 1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hC2,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hC0,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b1, utf8sd_pkg::CP_QMARK, 1'b1, 16'd1},
        '{8'hE0,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hA0,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hED,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hA0,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b1, utf8sd_pkg::CP_QMARK, 1'b1, 16'd2},
        '{8'h80,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hF4,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h90,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h80,                1'b0, 1'b1, utf8sd_pkg::CP_QMARK, 1'b1, 16'd3},
        '{8'hF8,                1'b0, 1'b1, utf8sd_pkg::CP_QMARK, 1'b1, 16'd4},
        '{8'hFF,                1'b0, 1'b1, utf8sd_pkg::CP_QMARK, 1'b1, 16'd5},
        '{8'hE2,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h41,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'hF0,                1'b0, 1'b0, 21'd0,                1'b0, 16'd0},
        '{8'h9F,                1'b1, 1'b0, 21'd0,                1'b0, 16'd0},
        '{utf8sd_pkg::BYTE_CR,  1'b1, 1'b1, 21'd0,                1'b0, 16'd0}
    };

    logic                               aclk        = 1'b0;
    logic                               aresetn     = 1'b0;
    logic                               s_tvalid    = 1'b0;
    logic                               s_tready;
    logic [utf8sd_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    logic                               s_tlast     = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready    = 1'b0;
    logic [utf8sd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [utf8sd_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                               m_tlast;
    logic                               cfg_wr_en   = 1'b0;
    logic [utf8sd_pkg::TAB_W-1:0]       cfg_wr_data = '0;

    // decoder model state
    logic [utf8sd_pkg::TAB_W-1:0]       tab_width   = utf8sd_pkg::TAB_WIDTH_RST;
    logic [CP_W-1:0]                    acc_val     = '0;
    logic [1:0]                         acc_left    = '0;
    logic [2:0]                         acc_len     = '0;
    logic                               skip_cont   = 1'b0;
    logic [CNT_W-1:0]                   bad_seqs    = '0;

    cp_result_t             byte_cps [20];
    int                     byte_cp_n;
    cp_result_t             expected_cps [$];
    cp_result_t             want;

    int                     src_idle_pct   = 0;
    int                     sink_stall_pct = 0;
    int                     hold_reqs      = 0;
    int                     hold_seen      = 0;
    int                     hold_left      = 0;
    int                     bytes_sent     = 0;
    int                     mismatches     = 0;
    int unsigned            cycles         = 0;

    utf8_stream_decoder_top #(
        .MAX_TAB_SPACES(TAB_MAX)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_top_tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cps.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("unexpected transfer: code_point 0x%0h", m_tdata[CP_W-1:0]);
            end else begin
                want = expected_cps.pop_front();
                check_field("code_point", want.cp, m_tdata[CP_W-1:0]);
                check_field("has_code_point", want.has, m_tuser[0]);
                check_field("last_of_run", want.last, m_tlast);
                check_field("text_done", want.done, m_tuser[1]);
                check_field("invalid_count", want.cnt, m_tdata[CP_W+CNT_W-1:CP_W]);
            end
        end
    end

    task automatic put_cp(input logic [CP_W-1:0] cp, input logic has);
        byte_cps[byte_cp_n] = '{cp, has, 1'b0, 1'b0, bad_seqs};
        byte_cp_n++;
    endtask

    task automatic put_qmark();
        if (bad_seqs != '1)
            bad_seqs++;
        put_cp(utf8sd_pkg::CP_QMARK, 1'b1);
    endtask

    task automatic clear_acc();
        acc_val  = '0;
        acc_left = '0;
        acc_len  = '0;
    endtask

    task automatic start_char(input logic [7:0] b);
        int w;
        w = (tab_width == 0) ? 1 : int'(tab_width);
        if (w > TAB_MAX)
            w = TAB_MAX;
        if (b == utf8sd_pkg::BYTE_CR) begin
        end else if (b == utf8sd_pkg::BYTE_TAB) begin
            repeat (w) put_cp(utf8sd_pkg::CP_SPACE, 1'b1);
        end else if (!b[7]) begin
            put_cp(CP_W'(b), 1'b1);
        end else if (b[7:5] == 3'b110) begin
            acc_val  = CP_W'(b[4:0]);
            acc_len  = utf8sd_pkg::SEQ_LEN2;
            acc_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            acc_val  = CP_W'(b[3:0]);
            acc_len  = utf8sd_pkg::SEQ_LEN3;
            acc_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            acc_val  = CP_W'(b[2:0]);
            acc_len  = utf8sd_pkg::SEQ_LEN4;
            acc_left = 2'd3;
        end else begin
            put_qmark();
            skip_cont = 1'b1;
        end
    endtask

    task automatic end_char();
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] lo;
        cp = acc_val;
        lo = (acc_len == utf8sd_pkg::SEQ_LEN2) ? utf8sd_pkg::CP_MIN2 :
             (acc_len == utf8sd_pkg::SEQ_LEN3) ? utf8sd_pkg::CP_MIN3 : utf8sd_pkg::CP_MIN4;
        clear_acc();
        if (cp >= lo && cp <= utf8sd_pkg::CP_MAX &&
            !(cp >= utf8sd_pkg::SURR_LO && cp <= utf8sd_pkg::SURR_HI)) begin
            put_cp(cp, 1'b1);
        end else begin
            put_qmark();
            skip_cont = 1'b1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        byte_cp_n = 0;
        if (acc_left != 0) begin
            if (b[7:6] == 2'b10) begin
                acc_val = {acc_val[CP_W-7:0], b[5:0]};
                acc_left--;
                if (acc_left == 0)
                    end_char();
            end else begin
                put_qmark();
                clear_acc();
                skip_cont = 1'b0;
                start_char(b);
            end
        end else if (!(skip_cont && b[7:6] == 2'b10)) begin
            skip_cont = 1'b0;
            start_char(b);
        end
        if (eot && acc_left != 0) begin
            put_qmark();
            clear_acc();
        end
        if (eot && byte_cp_n == 0)
            put_cp('0, 1'b0);
        if (byte_cp_n > 0) begin
            byte_cps[byte_cp_n-1].last = 1'b1;
            byte_cps[byte_cp_n-1].done = eot;
        end
        if (eot) begin
            clear_acc();
            skip_cont = 1'b0;
            bad_seqs  = '0;
        end
    endtask

    task automatic queue_predicted();
        for (int i = 0; i < byte_cp_n; i++)
            expected_cps.insert(expected_cps.size(), byte_cps[i]);
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic eot);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        decode_byte(b, eot);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        offer_byte(b, eot);
        queue_predicted();
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cps.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_tab(input logic [utf8sd_pkg::TAB_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tab_width    = v;
    endtask

    // one character: mostly well-formed, some malformed or truncated, some raw noise
    task automatic send_random_unit();
        int kind;
        int len;
        int extra;
        int cut;
        logic [CP_W-1:0] v;
        logic [7:0] unit_bytes [7];
        kind  = $urandom_range(99);
        len   = 1;
        extra = 0;
        v     = CP_W'($urandom);
        if (kind < 30) begin
            unit_bytes[0] = 8'($urandom_range(127));
        end else if (kind < 38) begin
            unit_bytes[0] = utf8sd_pkg::BYTE_TAB;
        end else if (kind < 43) begin
            unit_bytes[0] = utf8sd_pkg::BYTE_CR;
        end else if (kind < 56) begin
            len = 2;
            v   = CP_W'($urandom_range(utf8sd_pkg::CP_MIN2, utf8sd_pkg::CP_MIN3 - 1));
        end else if (kind < 68) begin
            len = 3;
            v   = CP_W'($urandom_range(utf8sd_pkg::CP_MIN3, utf8sd_pkg::CP_MIN4 - 1));
            if (v >= utf8sd_pkg::SURR_LO && v <= utf8sd_pkg::SURR_HI)
                v[12] = 1'b0;
        end else if (kind < 78) begin
            len = 4;
            v   = CP_W'($urandom_range(utf8sd_pkg::CP_MIN4, utf8sd_pkg::CP_MAX));
        end else if (kind < 90) begin
            len   = $urandom_range(2, 4);
            extra = $urandom_range(2);
        end else begin
            unit_bytes[0] = 8'($urandom_range(255));
        end
        case (len)
            2: begin
                unit_bytes[0] = {3'b110, v[10:6]};
                unit_bytes[1] = {2'b10, v[5:0]};
            end
            3: begin
                unit_bytes[0] = {4'b1110, v[15:12]};
                unit_bytes[1] = {2'b10, v[11:6]};
                unit_bytes[2] = {2'b10, v[5:0]};
            end
            4: begin
                unit_bytes[0] = {5'b11110, v[20:18]};
                unit_bytes[1] = {2'b10, v[17:12]};
                unit_bytes[2] = {2'b10, v[11:6]};
                unit_bytes[3] = {2'b10, v[5:0]};
            end
            default: begin
            end
        endcase
        for (int i = len; i < len + extra; i++)
            unit_bytes[i] = {2'b10, 6'($urandom)};
        cut = len + extra;
        if (kind >= 78 && kind < 90 && $urandom_range(2) == 0)
            cut = $urandom_range(1, len - 1);
        for (int i = 0; i < cut; i++)
            send_byte(unit_bytes[i], (i == cut - 1) && ($urandom_range(15) == 0));
    endtask

    initial begin : main_seq
        int base;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            offer_byte(DIR_ROWS[i].b, DIR_ROWS[i].eot);
            if (DIR_ROWS[i].typed)
                expected_cps.insert(expected_cps.size(),
                                    cp_result_t'{DIR_ROWS[i].cp, DIR_ROWS[i].has, 1'b1,
                                                 DIR_ROWS[i].eot, DIR_ROWS[i].cnt});
            else
                queue_predicted();
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p > 0)
                write_tab(TAB_SET[p]);
            src_idle_pct   = SRC_IDLE[p];
            sink_stall_pct = SINK_STALL[p];
            // long receiver hold-off while the sender keeps pushing
            if (p == 0)
                hold_reqs++;
            base = bytes_sent;
            while (bytes_sent - base < PHASE_BYTES)
                send_random_unit();
        end

        settle();
        if (mismatches == 0)
            $display("utf8_stream_decoder_top_tb OK");
        else
            $display("utf8_stream_decoder_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode.sv
hw/rtl/utf8_stream_decoder_top.sv
dv/utf8_stream_decoder_top_tb.sv
